@@ sv/bdrd_pkg.sv @@
// bdrd_pkg: shared constants and calendar helper functions for the
// business-day return date block. No dependencies.
package bdrd_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int WDAY_W  = 3;
   localparam int BDAYS_W = 12;

   // shared multiplier operand widths
   localparam int MUL_A_W = 15;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // floor(x/100) = (x*5243) >> 19, exact for x < 43698
   localparam logic [MUL_B_W-1:0] RECIP_100 = 17'd5243;
   // floor(x/7) = (x*74899) >> 19, exact for x < 32768
   localparam logic [MUL_B_W-1:0] RECIP_7   = 17'd74899;
   localparam int RECIP_SHIFT = 19;

   localparam logic [YEAR_W-1:0]  YEAR_MAX = 14'd16383;
   localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;
   localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
   localparam logic [WDAY_W-1:0]  FRIDAY   = 3'd5;
   localparam logic [WDAY_W-1:0]  SATURDAY = 3'd6;

   function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
      logic [DAY_W-1:0] len;
      unique case (month)
         4'd2:                 len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:              len = 5'd31;
      endcase
      return len;
   endfunction

   // floor(31*mm/12) for the March-based month number mm = 1..12
   function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] mm);
      logic [DAY_W-1:0] ofs;
      unique case (mm)
         4'd1:    ofs = 5'd2;
         4'd2:    ofs = 5'd5;
         4'd3:    ofs = 5'd7;
         4'd4:    ofs = 5'd10;
         4'd5:    ofs = 5'd12;
         4'd6:    ofs = 5'd15;
         4'd7:    ofs = 5'd18;
         4'd8:    ofs = 5'd20;
         4'd9:    ofs = 5'd23;
         4'd10:   ofs = 5'd25;
         4'd11:   ofs = 5'd28;
         4'd12:   ofs = 5'd31;
         default: ofs = 5'd0;
      endcase
      return ofs;
   endfunction

endpackage

@@ sv/bdrd_if.sv @@
// bdrd_if: valid/ready channel interfaces for request and response words.
// Depends on bdrd_pkg.
interface bdrd_req_if import bdrd_pkg::*;;
   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  start_year;
   logic [MONTH_W-1:0] start_month;
   logic [DAY_W-1:0]   start_day;
   logic [BDAYS_W-1:0] business_days;

   modport source (output valid, start_year, start_month, start_day, business_days,
                   input ready);
   modport sink   (input valid, start_year, start_month, start_day, business_days,
                   output ready);
endinterface

interface bdrd_rsp_if import bdrd_pkg::*;;
   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  return_year;
   logic [MONTH_W-1:0] return_month;
   logic [DAY_W-1:0]   return_day;
   logic [WDAY_W-1:0]  return_weekday;

   modport source (output valid, return_year, return_month, return_day, return_weekday,
                   input ready);
   modport sink   (input valid, return_year, return_month, return_day, return_weekday,
                   output ready);
endinterface

@@ sv/business_day_return_date.sv @@
// Business-day return date: takes a start date and a count of business days
// (Friday and Saturday are weekend) and returns the date reached after the
// count is used up, plus its weekday (0 = Sunday). A request word is taken in
// the idle state. The setup states DIVY, YMOD, DIVYY, SUM, MOD7A and MOD7B
// follow, in which one shared multiplier works out year/100 and the start
// weekday by reciprocal multiplication. Then comes one cycle per calendar day
// walked. The output register is loaded in the last RUN cycle; that load is
// held while the previous response word still waits in the output register.
// A new request word is taken only after that load, and then also while the
// finished response word still waits. Depends on bdrd_pkg, bdrd_if, bdrd_mul.
module business_day_return_date import bdrd_pkg::*; #(
   parameter int COUNT_WIDTH = 12
) (
   input logic        clock,
   input logic        reset,
   bdrd_req_if.sink   req_bus,
   bdrd_rsp_if.source rsp_bus
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIVY  = 3'd1;
   localparam logic [2:0] ST_YMOD  = 3'd2;
   localparam logic [2:0] ST_DIVYY = 3'd3;
   localparam logic [2:0] ST_SUM   = 3'd4;
   localparam logic [2:0] ST_MOD7A = 3'd5;
   localparam logic [2:0] ST_MOD7B = 3'd6;
   localparam logic [2:0] ST_RUN   = 3'd7;

   logic [2:0]             state_ff, state_in;
   logic [YEAR_W-1:0]      year_ff, year_in;
   logic [MONTH_W-1:0]     month_ff, month_in;
   logic [DAY_W-1:0]       day_ff, day_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [6:0]             y100_ff, y100_in;
   logic [8:0]             y400_ff, y400_in;
   logic [YEAR_W-1:0]      yy_ff, yy_in;
   logic [MONTH_W-1:0]     mm_ff, mm_in;
   logic [14:0]            sum_ff, sum_in;
   logic [WDAY_W-1:0]      wd_ff, wd_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [YEAR_W-1:0]      out_year_ff, out_year_in;
   logic [MONTH_W-1:0]     out_month_ff, out_month_in;
   logic [DAY_W-1:0]       out_day_ff, out_day_in;
   logic [WDAY_W-1:0]      out_wd_ff, out_wd_in;

   logic [MUL_A_W-1:0]     mul_a;
   logic [MUL_B_W-1:0]     mul_b;
   logic [MUL_P_W-1:0]     mul_p;

   logic [14:0]            bdays_ext;
   logic                   leap;
   logic [DAY_W-1:0]       dim;
   logic [7:0]             q100;
   logic [6:0]             r100;
   logic [12:0]            q7;
   logic                   early;

   bdrd_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   assign bdays_ext = 15'(req_bus.business_days);
   assign leap = ((year_ff[1:0] == 2'd0) && (y100_ff != 7'd0)) || (y400_ff == 9'd0);
   assign dim  = days_in_month(month_ff, leap);
   assign q100 = mul_p[RECIP_SHIFT+7:RECIP_SHIFT];
   assign r100 = 7'(year_ff - YEAR_W'(q100) * YEAR_W'(100));
   assign q7   = mul_p[MUL_P_W-1:RECIP_SHIFT];
   assign early = (month_ff <= FEBRUARY);

   always_comb begin
      mul_a = 15'(year_ff);
      mul_b = RECIP_100;
      unique case (state_ff)
         ST_DIVYY: begin
            mul_a = 15'(yy_ff);
            mul_b = RECIP_100;
         end
         ST_MOD7A: begin
            mul_a = sum_ff;
            mul_b = RECIP_7;
         end
         default: begin
            mul_a = 15'(year_ff);
            mul_b = RECIP_100;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      rem_in       = rem_ff;
      y100_in      = y100_ff;
      y400_in      = y400_ff;
      yy_in        = yy_ff;
      mm_in        = mm_ff;
      sum_in       = sum_ff;
      wd_in        = wd_ff;
      out_year_in  = out_year_ff;
      out_month_in = out_month_ff;
      out_day_in   = out_day_ff;
      out_wd_in    = out_wd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               year_in = (req_bus.start_year == '0) ? YEAR_W'(1) : req_bus.start_year;
               if (req_bus.start_month == '0) begin
                  month_in = MONTH_W'(1);
               end else if (req_bus.start_month > DECEMBER) begin
                  month_in = DECEMBER;
               end else begin
                  month_in = req_bus.start_month;
               end
               day_in   = req_bus.start_day;
               rem_in   = bdays_ext[COUNT_WIDTH-1:0];
               state_in = ST_DIVY;
            end
         end
         ST_DIVY: begin
            state_in = ST_YMOD;
         end
         ST_YMOD: begin
            y100_in  = r100;
            y400_in  = 9'(q100[1:0]) * 9'd100 + 9'(r100);
            yy_in    = year_ff - YEAR_W'(early);
            mm_in    = early ? month_ff + 4'd10 : month_ff - 4'd2;
            state_in = ST_DIVYY;
         end
         ST_DIVYY: begin
            // clamp the start day into the month
            if (day_ff == '0) begin
               day_in = DAY_W'(1);
            end else if (day_ff > dim) begin
               day_in = dim;
            end
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sum_in = 15'(16'(day_ff) + 16'(yy_ff) + 16'(yy_ff[YEAR_W-1:2])
                         + 16'(q100[7:2]) + 16'(month_offset(mm_ff)) - 16'(q100));
            state_in = ST_MOD7A;
         end
         ST_MOD7A: begin
            state_in = ST_MOD7B;
         end
         ST_MOD7B: begin
            wd_in    = 3'(sum_ff - 15'(q7) * 15'd7);
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (rem_ff == '0) begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  out_year_in  = year_ff;
                  out_month_in = month_ff;
                  out_day_in   = day_ff;
                  out_wd_in    = wd_ff;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               if ((wd_ff != FRIDAY) && (wd_ff != SATURDAY)) begin
                  rem_in = rem_ff - COUNT_WIDTH'(1);
               end
               if (day_ff >= dim) begin
                  day_in = DAY_W'(1);
                  if (month_ff == DECEMBER) begin
                     month_in = MONTH_W'(1);
                     if (year_ff >= YEAR_MAX) begin
                        year_in = YEAR_W'(1);
                        y100_in = 7'd1;
                        y400_in = 9'd1;
                     end else begin
                        year_in = year_ff + YEAR_W'(1);
                        y100_in = (y100_ff == 7'd99) ? 7'd0 : y100_ff + 7'd1;
                        y400_in = (y400_ff == 9'd399) ? 9'd0 : y400_ff + 9'd1;
                     end
                  end else begin
                     month_in = month_ff + MONTH_W'(1);
                  end
               end else begin
                  day_in = day_ff + DAY_W'(1);
               end
               wd_in = (wd_ff == SATURDAY) ? 3'd0 : wd_ff + 3'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      year_ff      <= year_in;
      month_ff     <= month_in;
      day_ff       <= day_in;
      rem_ff       <= rem_in;
      y100_ff      <= y100_in;
      y400_ff      <= y400_in;
      yy_ff        <= yy_in;
      mm_ff        <= mm_in;
      sum_ff       <= sum_in;
      wd_ff        <= wd_in;
      out_year_ff  <= out_year_in;
      out_month_ff <= out_month_in;
      out_day_ff   <= out_day_in;
      out_wd_ff    <= out_wd_in;
   end

   assign req_bus.ready          = (state_ff == ST_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.return_year    = out_year_ff;
   assign rsp_bus.return_month   = out_month_ff;
   assign rsp_bus.return_day     = out_day_ff;
   assign rsp_bus.return_weekday = out_wd_ff;

endmodule

@@ sv/bdrd_mul.sv @@
// bdrd_mul: shared multiplier with a registered product, used for the
// reciprocal divisions. Depends on bdrd_pkg.
module bdrd_mul import bdrd_pkg::*; (
   input  logic               clock,
   input  logic [MUL_A_W-1:0] op_a,
   input  logic [MUL_B_W-1:0] op_b,
   output logic [MUL_P_W-1:0] product
);

   logic [MUL_P_W-1:0] product_ff;
   logic [MUL_P_W-1:0] product_in;

   assign product_in = MUL_P_W'(op_a) * MUL_P_W'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

@@ test/business_day_return_date_check.sv @@
// business_day_return_date_check: watches the request and response channels,
// predicts each return date and compares it field by field with the response.
// Depends on bdrd_pkg and bdrd_if.
module business_day_return_date_check import bdrd_pkg::*; #(
   parameter int COUNT_WIDTH = 12
) (
   input  logic        clock,
   input  logic        reset,
   bdrd_req_if         req_bus,
   bdrd_rsp_if         rsp_bus,
   output int unsigned pending_words,
   output int unsigned mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [WDAY_W-1:0]  weekday;
   } return_date_type;

   return_date_type due_dates[$];
   int unsigned     rsp_count = 0;

   initial begin
      pending_words  = 0;
      mismatch_count = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: response word %0d: %s", $time, rsp_count, msg);
      mismatch_count++;
   endtask

   function automatic int unsigned month_length(input int unsigned month,
                                                input int unsigned year);
      bit leap;
      leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
      case (month)
         FEBRUARY:        return leap ? 29 : 28;
         4, 6, 9, 11:     return 30;
         default:         return 31;
      endcase
   endfunction

   function automatic return_date_type project_return_date(
         input logic [YEAR_W-1:0]  y_in,
         input logic [MONTH_W-1:0] m_in,
         input logic [DAY_W-1:0]   d_in,
         input logic [BDAYS_W-1:0] n_in);
      int unsigned     year, month, day, wday, left, shift, yy, mm;
      return_date_type r;
      year  = (y_in == 0) ? 1 : y_in;
      month = (m_in == 0) ? 1 : ((m_in > DECEMBER) ? DECEMBER : m_in);
      day   = (d_in == 0) ? 1 : d_in;
      if (day > month_length(month, year))
         day = month_length(month, year);

      // weekday of the start date, year counted from March
      shift = (14 - month) / 12;
      yy    = year - shift;
      mm    = month + 12 * shift - 2;
      wday  = (day + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;

      left = n_in & ((1 << COUNT_WIDTH) - 1);
      while (left != 0) begin
         if (wday != FRIDAY && wday != SATURDAY)
            left--;
         if (day >= month_length(month, year)) begin
            day = 1;
            if (month == DECEMBER) begin
               month = 1;
               year  = (year >= YEAR_MAX) ? 1 : year + 1;
            end else begin
               month++;
            end
         end else begin
            day++;
         end
         wday = (wday + 1) % 7;
      end

      r.year    = YEAR_W'(year);
      r.month   = MONTH_W'(month);
      r.day     = DAY_W'(day);
      r.weekday = WDAY_W'(wday);
      return r;
   endfunction

   always @(posedge clock) begin
      return_date_type want;
      if (reset) begin
         due_dates.delete();
      end else begin
         if (req_bus.valid && req_bus.ready)
            due_dates.push_back(project_return_date(req_bus.start_year, req_bus.start_month,
                                                    req_bus.start_day, req_bus.business_days));
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_dates.size() == 0) begin
               report_mismatch("arrived with no request pending");
            end else begin
               want = due_dates.pop_front();
               if (rsp_bus.return_year !== want.year)
                  report_mismatch($sformatf("year %0d, expected %0d",
                                            rsp_bus.return_year, want.year));
               if (rsp_bus.return_month !== want.month)
                  report_mismatch($sformatf("month %0d, expected %0d",
                                            rsp_bus.return_month, want.month));
               if (rsp_bus.return_day !== want.day)
                  report_mismatch($sformatf("day %0d, expected %0d",
                                            rsp_bus.return_day, want.day));
               if (rsp_bus.return_weekday !== want.weekday)
                  report_mismatch($sformatf("weekday %0d, expected %0d",
                                            rsp_bus.return_weekday, want.weekday));
            end
            rsp_count++;
         end
      end
      pending_words = due_dates.size();
   end

endmodule

@@ test/business_day_return_date_tb.sv @@
// business_day_return_date_tb: drives directed and random start dates into the
// block with bursty requests and a stalling receiver; checking is done by
// business_day_return_date_check. Depends on bdrd_pkg, bdrd_if and the RTL.
module business_day_return_date_tb import bdrd_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COUNT_WIDTH  = 12;
   localparam int RANDOM_WORDS = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned pending_words;
   int unsigned mismatch_count;

   bdrd_req_if req_bus ();
   bdrd_rsp_if rsp_bus ();

   business_day_return_date #(.COUNT_WIDTH(COUNT_WIDTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   business_day_return_date_check #(.COUNT_WIDTH(COUNT_WIDTH)) check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .pending_words  (pending_words),
      .mismatch_count (mismatch_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // called at a falling edge; returns at the falling edge after the handshake
   task automatic send_word(input logic [YEAR_W-1:0]  year,
                            input logic [MONTH_W-1:0] month,
                            input logic [DAY_W-1:0]   day,
                            input logic [BDAYS_W-1:0] count);
      req_bus.valid         = 1'b1;
      req_bus.start_year    = year;
      req_bus.start_month   = month;
      req_bus.start_day     = day;
      req_bus.business_days = count;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid = 1'b0;
      while (pending_words != 0)
         @(negedge clock);
   endtask

   // receiver: segments of always-ready, coin-flip, short and long periodic stalls
   initial begin
      int unsigned style, span, phase;
      rsp_bus.ready = 1'b0;
      phase = 0;
      forever begin
         style = $urandom_range(0, 3);
         span  = $urandom_range(16, 160);
         repeat (span) begin
            @(negedge clock);
            case (style)
               0:       rsp_bus.ready = 1'b1;
               1:       rsp_bus.ready = 1'($urandom_range(0, 1));
               2:       rsp_bus.ready = (phase % 7) >= 3;
               default: rsp_bus.ready = (phase % 40) >= 25;
            endcase
            phase++;
         end
      end
   end

   initial begin
      int unsigned sent, burst, gap, pick;
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [BDAYS_W-1:0] count;
      bit                 paused;

      req_bus.valid         = 1'b0;
      req_bus.start_year    = '0;
      req_bus.start_month   = '0;
      req_bus.start_day     = '0;
      req_bus.business_days = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed words
      send_word(14'd2024, 4'd6, 5'd15, 12'd0);       // zero count, Saturday start
      send_word(14'd2024, 4'd5, 5'd31, 12'd1);       // Friday start
      send_word(14'd2024, 4'd6, 5'd1, 12'd1);        // Saturday start
      send_word(14'd2024, 4'd6, 5'd2, 12'd1);        // Sunday start
      send_word(14'd0, 4'd3, 5'd1, 12'd5);           // year zero
      send_word(14'd2023, 4'd0, 5'd10, 12'd3);       // month zero
      send_word(14'd2023, 4'd13, 5'd10, 12'd3);      // month past December
      send_word(14'd2023, 4'd15, 5'd31, 12'd2);
      send_word(14'd2023, 4'd4, 5'd0, 12'd4);        // day zero
      send_word(14'd2023, 4'd4, 5'd31, 12'd4);       // day past end of April
      send_word(14'd2000, 4'd2, 5'd31, 12'd1);       // leap by the 400 rule
      send_word(14'd1900, 4'd2, 5'd30, 12'd2);       // not leap by the 100 rule
      send_word(14'd2024, 4'd2, 5'd28, 12'd3);
      send_word(14'd2023, 4'd2, 5'd28, 12'd3);
      send_word(14'd2024, 4'd12, 5'd31, 12'd1);      // year rollover
      send_word(YEAR_MAX, 4'd12, 5'd31, 12'd3);      // year counter wraps
      send_word(YEAR_MAX, 4'd12, 5'd20, 12'd10);
      send_word(14'd9999, 4'd12, 5'd31, 12'd1);
      send_word(14'd1, 4'd1, 5'd1, 12'd4095);        // longest walk
      send_word(14'h3FFF, 4'hF, 5'h1F, 12'hFFF);     // every bit high
      send_word(14'd0, 4'd0, 5'd0, 12'd0);           // every bit low
      send_word(14'h1555, 4'h5, 5'h15, 12'h555);
      send_word(14'h2AAA, 4'hA, 5'h0A, 12'hAAA);
      drain();

      sent   = 0;
      paused = 1'b0;
      while (sent < RANDOM_WORDS) begin
         burst = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
         for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
            pick  = $urandom_range(0, 99);
            year  = YEAR_W'((pick < 85) ? $urandom_range(1, 9999) : $urandom_range(0, 16383));
            pick  = $urandom_range(0, 99);
            month = MONTH_W'((pick < 90) ? $urandom_range(1, 12) : $urandom_range(0, 15));
            pick  = $urandom_range(0, 99);
            day   = DAY_W'((pick < 80) ? $urandom_range(1, 28) :
                           (pick < 95) ? $urandom_range(29, 31) : $urandom_range(0, 31));
            pick  = $urandom_range(0, 99);
            count = BDAYS_W'((pick < 65) ? $urandom_range(0, 63) :
                             (pick < 90) ? $urandom_range(64, 700) : $urandom_range(0, 4095));
            if ($urandom_range(0, 19) == 0) begin
               // run off the end of the year counter
               year  = YEAR_W'($urandom_range(16380, 16383));
               month = DECEMBER;
               day   = DAY_W'($urandom_range(20, 31));
            end
            send_word(year, month, day, count);
            sent++;
         end
         if (!paused && sent >= RANDOM_WORDS / 2) begin
            paused = 1'b1;
            drain();
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
         if (gap != 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end

      drain();
      repeat (50) @(negedge clock);
      if (mismatch_count == 0)
         $display("business_day_return_date regression: pass");
      else
         $display("business_day_return_date regression: fail");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("business_day_return_date regression: fail");
      $finish;
   end

endmodule
